// ----- src/bpss_pkg.sv -----
// ----------------------------------------------------------------------------
// bpss_pkg: shared types and constants for the balance steering unit
// Item and result layouts, configuration set, register indexes and motor codes.
// ----------------------------------------------------------------------------
package bpss_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned GAIN_W     = 20;
  localparam int unsigned ILIM_W     = 24;
  localparam int unsigned DLIM_W     = 7;
  localparam int unsigned ANGLE_W    = 17;
  localparam int unsigned RATE_W     = 16;
  localparam int unsigned DRIVE_W    = 8;
  localparam int unsigned CMD_W      = 3;

  localparam logic [GAIN_W-1:0] KP_RESET   = 20'd3072;  // 12.0 in Q12.8
  localparam logic [GAIN_W-1:0] KI_RESET   = 20'd0;
  localparam logic [GAIN_W-1:0] KD_RESET   = 20'd0;
  localparam logic [ILIM_W-1:0] ILIM_RESET = 24'd25600;
  localparam logic [DLIM_W-1:0] DLIM_RESET = 7'd100;
  localparam logic [DLIM_W-1:0] DRIVE_CAP  = 7'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP_GAIN        = 3'd0,
    CFG_KI_GAIN        = 3'd1,
    CFG_KD_GAIN        = 3'd2,
    CFG_INTEGRAL_LIMIT = 3'd3,
    CFG_DRIVE_LIMIT    = 3'd4
  } cfg_idx_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_STOP    = 3'd0,
    CMD_FORWARD = 3'd1,
    CMD_REVERSE = 3'd2,
    CMD_LEFT    = 3'd3,
    CMD_RIGHT   = 3'd4
  } motor_cmd_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] kp_gain;
    logic signed [GAIN_W-1:0] ki_gain;
    logic signed [GAIN_W-1:0] kd_gain;
    logic [ILIM_W-1:0]        integral_limit;
    logic [DLIM_W-1:0]        drive_limit;
  } cfg_t;

  typedef struct packed {
    logic                      run;
    logic                      sample_valid;
    logic signed [ANGLE_W-1:0] pitch_angle;
    logic signed [RATE_W-1:0]  angular_rate;
    logic                      front_left_line;
    logic                      front_right_line;
    logic                      rear_left_line;
    logic                      rear_right_line;
  } in_item_t;

  typedef struct packed {
    motor_cmd_t                motor_command;
    logic signed [DRIVE_W-1:0] drive_value;
  } result_t;

endpackage

// ----- src/bpss_in_reg.sv -----
// ----------------------------------------------------------------------------
// bpss_in_reg: input register stage
// Captures one tick word and holds it until the compute stage takes it.
// ----------------------------------------------------------------------------
module bpss_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bpss_pkg::in_item_t in_item,
  input  logic               take,
  output logic               s_valid,
  output bpss_pkg::in_item_t s_item
);

  logic               valid_r;
  logic               valid_nxt;
  bpss_pkg::in_item_t item_r;
  logic               load;

  assign in_ready = !valid_r || take;
  assign load     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign s_valid = valid_r;
  assign s_item  = item_r;

endmodule

// ----- src/bpss_core.sv -----
// ----------------------------------------------------------------------------
// bpss_core: pid, soft pwm gate and steering
// Holds integral, duty counter and held command; updates them once per tick.
// ----------------------------------------------------------------------------
module bpss_core #(
  parameter int unsigned DUTY_PERIOD = 100
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bpss_pkg::cfg_t     cfg,
  input  logic               fire,
  input  bpss_pkg::in_item_t item,
  output bpss_pkg::result_t  result
);

  localparam int unsigned CW   = $clog2(DUTY_PERIOD);
  localparam int unsigned CMPW = (CW > 7) ? CW : 7;
  localparam int unsigned IW   = bpss_pkg::ILIM_W + 1;  // clamped integral
  localparam int unsigned SW   = bpss_pkg::ILIM_W + 2;  // integral before clamp
  localparam int unsigned AW   = 47;                    // pid sum in q16

  logic signed [IW-1:0]         integral_r, integral_nxt;
  logic [CW-1:0]                duty_cnt_r, duty_cnt_nxt;
  bpss_pkg::motor_cmd_t         held_cmd_r, held_cmd_nxt;
  logic signed [bpss_pkg::DRIVE_W-1:0] held_drive_r, held_drive_nxt;

  logic signed [SW-1:0] int_sum;
  logic signed [SW-1:0] lim_pos;
  logic signed [IW-1:0] int_new;
  logic signed [36:0]   p_kp;
  logic signed [44:0]   p_ki;
  logic signed [35:0]   p_kd;
  logic signed [AW-1:0] acc;
  logic [bpss_pkg::DLIM_W-1:0] dl;
  logic signed [AW-1:0] cap;
  logic signed [23:0]   acc_c;
  logic signed [23:0]   acc_t;
  logic signed [bpss_pkg::DRIVE_W-1:0] drive;
  logic signed [bpss_pkg::DRIVE_W-1:0] drive_neg;
  logic [CMPW-1:0]      mag;
  logic [CMPW-1:0]      cnt_ext;
  bpss_pkg::motor_cmd_t steer_cmd;

  // integral step with symmetric clamp
  always_comb begin
    int_sum = SW'(integral_r) + SW'(item.pitch_angle);
    lim_pos = $signed({2'b00, cfg.integral_limit});
    if (int_sum > lim_pos) begin
      int_new = IW'(lim_pos);
    end else if (int_sum < -lim_pos) begin
      int_new = IW'(-lim_pos);
    end else begin
      int_new = IW'(int_sum);
    end
  end

  // three products, summed in q16
  always_comb begin
    p_kp = 37'(cfg.kp_gain) * 37'(item.pitch_angle);
    p_ki = 45'(cfg.ki_gain) * 45'(int_new);
    p_kd = 36'(cfg.kd_gain) * 36'(item.angular_rate);
    acc  = AW'(p_kp) + AW'(p_ki) + (AW'(p_kd) <<< 8);
  end

  // output clamp, then truncate toward zero
  always_comb begin
    dl  = (cfg.drive_limit > bpss_pkg::DRIVE_CAP) ? bpss_pkg::DRIVE_CAP : cfg.drive_limit;
    cap = $signed({{(AW-23){1'b0}}, dl, 16'h0000});
    if (acc > cap) begin
      acc_c = 24'(cap);
    end else if (acc < -cap) begin
      acc_c = 24'(-cap);
    end else begin
      acc_c = 24'(acc);
    end
    acc_t     = acc_c[23] ? (acc_c + 24'sh00FFFF) : acc_c;
    drive     = acc_t[23:16];
    drive_neg = -drive;
    mag       = drive[bpss_pkg::DRIVE_W-1] ? CMPW'(drive_neg[6:0]) : CMPW'(drive[6:0]);
    cnt_ext   = CMPW'(duty_cnt_r);
  end

  // a negative drive means forward: front pair steers, else rear pair
  always_comb begin
    if (drive[bpss_pkg::DRIVE_W-1]) begin
      if (!item.front_left_line && item.front_right_line) begin
        steer_cmd = bpss_pkg::CMD_RIGHT;
      end else if (item.front_left_line && !item.front_right_line) begin
        steer_cmd = bpss_pkg::CMD_LEFT;
      end else begin
        steer_cmd = bpss_pkg::CMD_FORWARD;
      end
    end else begin
      if (!item.rear_left_line && item.rear_right_line) begin
        steer_cmd = bpss_pkg::CMD_LEFT;
      end else if (item.rear_left_line && !item.rear_right_line) begin
        steer_cmd = bpss_pkg::CMD_RIGHT;
      end else begin
        steer_cmd = bpss_pkg::CMD_REVERSE;
      end
    end
  end

  always_comb begin
    integral_nxt   = integral_r;
    duty_cnt_nxt   = duty_cnt_r;
    held_cmd_nxt   = held_cmd_r;
    held_drive_nxt = held_drive_r;
    if (!item.run) begin
      integral_nxt = '0;
      duty_cnt_nxt = '0;
      held_cmd_nxt = bpss_pkg::CMD_STOP;
    end else begin
      if (item.sample_valid) begin
        integral_nxt   = int_new;
        held_drive_nxt = drive;
        held_cmd_nxt   = (cnt_ext < mag) ? steer_cmd : bpss_pkg::CMD_STOP;
      end
      if (duty_cnt_r == CW'(DUTY_PERIOD - 1)) begin
        duty_cnt_nxt = '0;
      end else begin
        duty_cnt_nxt = duty_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_r   <= '0;
      duty_cnt_r   <= '0;
      held_cmd_r   <= bpss_pkg::CMD_STOP;
      held_drive_r <= '0;
    end else if (fire) begin
      integral_r   <= integral_nxt;
      duty_cnt_r   <= duty_cnt_nxt;
      held_cmd_r   <= held_cmd_nxt;
      held_drive_r <= held_drive_nxt;
    end
  end

  assign result.motor_command = held_cmd_nxt;
  assign result.drive_value   = held_drive_nxt;

endmodule

// ----- src/bpss_out_reg.sv -----
// ----------------------------------------------------------------------------
// bpss_out_reg: result register
// Holds one result word until the downstream side takes it.
// ----------------------------------------------------------------------------
module bpss_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s_valid,
  input  bpss_pkg::result_t s_result,
  output logic              advance,
  output logic              out_valid,
  input  logic              out_ready,
  output bpss_pkg::result_t out_result
);

  logic              valid_r;
  logic              valid_nxt;
  bpss_pkg::result_t result_r;
  logic              load;

  assign advance = !valid_r || out_ready;
  assign load    = s_valid && advance;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= s_result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

// ----- src/balance_pid_soft_pwm_steering_unit.sv -----
// path: an accepted tick word goes into the input register, then into the result
//   register once that register has room; only then can its result be taken
// throughput: one word per cycle while out_tready stays high; pid, pwm gate and
//   steering settle in one pass between the input register and the result register
// the input side stalls only while both registers are full and out_tready is low
// reset (rst_n low, synchronous): registers return to defaults, integral, duty
//   counter and held drive clear, held command is stop, both channels empty
// ----------------------------------------------------------------------------
// balance_pid_soft_pwm_steering_unit: balance controller top level
// Positional pid with integral clamp driving a soft pwm and line steering.
// ----------------------------------------------------------------------------
module balance_pid_soft_pwm_steering_unit #(
  parameter int unsigned DUTY_PERIOD = 100
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [16:0] pitch_angle, [32:17] angular_rate, [33] front_left_line,
  // [34] front_right_line, [35] rear_left_line, [36] rear_right_line
  input  logic [39:0] in_tdata,
  // [0] run, [1] sample_valid
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [2:0] motor_command, [10:3] drive_value
  output logic [15:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [bpss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpss_pkg::CFG_DATA_W-1:0] cfg_data
);

  bpss_pkg::cfg_t     cfg_r;
  bpss_pkg::cfg_t     cfg_nxt;
  bpss_pkg::in_item_t in_item;
  bpss_pkg::in_item_t s_item;
  bpss_pkg::result_t  core_result;
  bpss_pkg::result_t  out_result;
  logic               s_valid;
  logic               advance;
  logic               fire;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (bpss_pkg::cfg_idx_t'(cfg_index))
        bpss_pkg::CFG_KP_GAIN:        cfg_nxt.kp_gain        = cfg_data[19:0];
        bpss_pkg::CFG_KI_GAIN:        cfg_nxt.ki_gain        = cfg_data[19:0];
        bpss_pkg::CFG_KD_GAIN:        cfg_nxt.kd_gain        = cfg_data[19:0];
        bpss_pkg::CFG_INTEGRAL_LIMIT: cfg_nxt.integral_limit = cfg_data;
        bpss_pkg::CFG_DRIVE_LIMIT:    cfg_nxt.drive_limit    = cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp_gain        <= bpss_pkg::KP_RESET;
      cfg_r.ki_gain        <= bpss_pkg::KI_RESET;
      cfg_r.kd_gain        <= bpss_pkg::KD_RESET;
      cfg_r.integral_limit <= bpss_pkg::ILIM_RESET;
      cfg_r.drive_limit    <= bpss_pkg::DLIM_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_item.run              = in_tuser[0];
  assign in_item.sample_valid     = in_tuser[1];
  assign in_item.pitch_angle      = in_tdata[16:0];
  assign in_item.angular_rate     = in_tdata[32:17];
  assign in_item.front_left_line  = in_tdata[33];
  assign in_item.front_right_line = in_tdata[34];
  assign in_item.rear_left_line   = in_tdata[35];
  assign in_item.rear_right_line  = in_tdata[36];

  bpss_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .take     (advance),
    .s_valid  (s_valid),
    .s_item   (s_item)
  );

  // state moves exactly when the staged word enters the result register
  assign fire = s_valid && advance;

  bpss_core #(
    .DUTY_PERIOD (DUTY_PERIOD)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .fire   (fire),
    .item   (s_item),
    .result (core_result)
  );

  bpss_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .s_valid    (s_valid),
    .s_result   (core_result),
    .advance    (advance),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (out_result)
  );

  assign out_tdata = {5'b00000, out_result.drive_value, out_result.motor_command};

  // input side only blocks when the result word is stuck downstream
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without a blocked result");

  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_result.drive_value) <= 8'sd100 &&
                    $signed(out_result.drive_value) >= -8'sd100))
    else $error("drive value beyond duty range");

  // a moving command always comes with a nonzero drive
  a_move_needs_drive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_result.motor_command != bpss_pkg::CMD_STOP) |->
      (out_result.drive_value != '0))
    else $error("motor moving with zero drive");

  a_one_word_per_fire: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_tvalid)
    else $error("taken word did not reach the result register");

endmodule

// ----- tb/sv/balance_pid_soft_pwm_steering_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// balance_pid_soft_pwm_steering_unit_test: self-checking bench for the balance unit
// Streams control ticks through the unit under random stalls on both sides,
// predicts every motor command and drive value with a local pid, duty gate
// and steering model, and walks the gains and limits through several
// settings, extremes included.
// ----------------------------------------------------------------------------
module balance_pid_soft_pwm_steering_unit_test;
  import bpss_pkg::*;

  localparam int DUTY_STEPS      = 100;
  localparam int TICK_PHASES     = 8;
  localparam int TICKS_PER_PHASE = 135;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [39:0]           in_tdata   = '0;
  logic [1:0]            in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [15:0]           out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  cfg_idx_t              cfg_index  = CFG_KP_GAIN;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  // local copy of the register set
  logic signed [GAIN_W-1:0] kp_q   = KP_RESET;
  logic signed [GAIN_W-1:0] ki_q   = KI_RESET;
  logic signed [GAIN_W-1:0] kd_q   = KD_RESET;
  logic [ILIM_W-1:0]        ilim_q = ILIM_RESET;
  logic [DLIM_W-1:0]        dlim_q = DLIM_RESET;

  // controller state as seen by the predictor
  longint                    integ_acc = 0;
  int                        duty_pos  = 0;
  motor_cmd_t                held_cmd  = CMD_STOP;
  logic signed [DRIVE_W-1:0] held_drv  = '0;

  in_item_t tick_q[$];
  result_t  motor_expect_q[$];
  in_item_t tick_on_bus;
  int       in_gap         = 0;
  int       out_stall      = 0;
  int       idle_level     = 2;
  int       mismatch_count = 0;

  balance_pid_soft_pwm_steering_unit #(
    .DUTY_PERIOD(DUTY_STEPS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  task automatic note_mismatch(input string what, input longint want, input longint got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
    end
  endtask

  task automatic predict_motor_result(input in_item_t t);
    longint  err;
    longint  lim;
    longint  acc;
    longint  cap;
    longint  dl;
    longint  drv;
    longint  mag;
    result_t r;
    if (!t.run) begin
      integ_acc = 0;
      duty_pos  = 0;
      held_cmd  = CMD_STOP;
    end else begin
      if (t.sample_valid) begin
        err = t.pitch_angle;
        lim = ilim_q;
        integ_acc += err;
        if (integ_acc > lim) integ_acc = lim;
        else if (integ_acc < -lim) integ_acc = -lim;
        acc = longint'(kp_q) * err + longint'(ki_q) * integ_acc
            + longint'(kd_q) * longint'(t.angular_rate) * 256;
        dl  = (dlim_q > DRIVE_CAP) ? DRIVE_CAP : dlim_q;
        cap = dl * 65536;
        if (acc > cap) acc = cap;
        else if (acc < -cap) acc = -cap;
        drv      = acc / 65536;  // truncates toward zero
        held_drv = drv[DRIVE_W-1:0];
        mag      = (drv < 0) ? -drv : drv;
        if (duty_pos < mag) begin
          if (drv < 0) begin
            if (!t.front_left_line && t.front_right_line) held_cmd = CMD_RIGHT;
            else if (t.front_left_line && !t.front_right_line) held_cmd = CMD_LEFT;
            else held_cmd = CMD_FORWARD;
          end else begin
            if (!t.rear_left_line && t.rear_right_line) held_cmd = CMD_LEFT;
            else if (t.rear_left_line && !t.rear_right_line) held_cmd = CMD_RIGHT;
            else held_cmd = CMD_REVERSE;
          end
        end else begin
          held_cmd = CMD_STOP;
        end
      end
      duty_pos = (duty_pos + 1) % DUTY_STEPS;
    end
    r.motor_command = held_cmd;
    r.drive_value   = held_drv;
    motor_expect_q.push_back(r);
  endtask

  // tick driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_tvalid && in_tready) predict_motor_result(tick_on_bus);
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (tick_q.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (idle_level != 0 &&
                     $urandom_range(0, (idle_level == 1) ? 24 : 6) == 0) begin
          in_gap = $urandom_range(0, 13);
          in_tvalid <= 1'b0;
        end else begin
          tick_on_bus = tick_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {3'b000, tick_on_bus.rear_right_line, tick_on_bus.rear_left_line,
                        tick_on_bus.front_right_line, tick_on_bus.front_left_line,
                        tick_on_bus.angular_rate, tick_on_bus.pitch_angle};
          in_tuser  <= {tick_on_bus.sample_valid, tick_on_bus.run};
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (motor_expect_q.size() == 0) begin
          note_mismatch("unexpected result word", 0, out_tdata);
        end else begin
          want = motor_expect_q.pop_front();
          if (out_tdata[2:0] != want.motor_command)
            note_mismatch("motor_command", want.motor_command, out_tdata[2:0]);
          if (out_tdata[10:3] != want.drive_value)
            note_mismatch("drive_value", want.drive_value, $signed(out_tdata[10:3]));
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else if (idle_level != 0 &&
                   $urandom_range(0, (idle_level == 1) ? 20 : 5) == 0) begin
        out_stall = $urandom_range(0, 13);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic in_item_t mk_tick(input int run, input int valid, input int pitch,
                                       input int rate, input int fl, input int fr,
                                       input int rl, input int rr);
    in_item_t t;
    t.run              = run[0];
    t.sample_valid     = valid[0];
    t.pitch_angle      = pitch[ANGLE_W-1:0];
    t.angular_rate     = rate[RATE_W-1:0];
    t.front_left_line  = fl[0];
    t.front_right_line = fr[0];
    t.rear_left_line   = rl[0];
    t.rear_right_line  = rr[0];
    return t;
  endfunction

  // random gain of random magnitude, junk above the 20 bits that count
  function automatic logic [CFG_DATA_W-1:0] rand_gain();
    int unsigned nbits;
    int          v;
    nbits = $urandom_range(1, GAIN_W);
    v = int'($urandom & ((32'd1 << nbits) - 1));
    if (nbits < GAIN_W && $urandom_range(0, 1) == 1) v = -v;
    return {4'($urandom), v[GAIN_W-1:0]};
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_KP_GAIN:        kp_q   = val[GAIN_W-1:0];
      CFG_KI_GAIN:        ki_q   = val[GAIN_W-1:0];
      CFG_KD_GAIN:        kd_q   = val[GAIN_W-1:0];
      CFG_INTEGRAL_LIMIT: ilim_q = val[ILIM_W-1:0];
      CFG_DRIVE_LIMIT:    dlim_q = val[DLIM_W-1:0];
      default: ;
    endcase
  endtask

  // every tick makes a result, so drained means nothing left in flight
  task automatic wait_drained();
    while (tick_q.size() != 0 || in_tvalid || motor_expect_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    in_item_t    t;
    int unsigned nbits;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int ph = 0; ph < TICK_PHASES; ph++) begin
      if (ph > 0) begin
        wait_drained();
        case (ph)
          1: begin
            write_reg(CFG_KP_GAIN, 24'hA80000);
            write_reg(CFG_KI_GAIN, 24'h07FFFF);
            write_reg(CFG_KD_GAIN, 24'h000000);
            write_reg(CFG_INTEGRAL_LIMIT, 24'hFFFFFF);
            write_reg(CFG_DRIVE_LIMIT, 24'd127);
          end
          2: begin
            write_reg(CFG_KP_GAIN, 24'h07FFFF);
            write_reg(CFG_KI_GAIN, 24'h080000);
            write_reg(CFG_KD_GAIN, 24'h07FFFF);
            write_reg(CFG_INTEGRAL_LIMIT, 24'h000000);
            write_reg(CFG_DRIVE_LIMIT, 24'd0);
          end
          3: begin
            write_reg(CFG_KP_GAIN, 24'h000000);
            write_reg(CFG_KI_GAIN, 24'h000001);
            write_reg(CFG_KD_GAIN, 24'h080000);
            write_reg(CFG_INTEGRAL_LIMIT, 24'h000001);
            write_reg(CFG_DRIVE_LIMIT, 24'd1);
          end
          default: begin
            write_reg(CFG_KP_GAIN, rand_gain());
            write_reg(CFG_KI_GAIN, rand_gain());
            write_reg(CFG_KD_GAIN, rand_gain());
            nbits = $urandom_range(1, ILIM_W);
            write_reg(CFG_INTEGRAL_LIMIT, CFG_DATA_W'($urandom & ((32'd1 << nbits) - 1)));
            write_reg(CFG_DRIVE_LIMIT, CFG_DATA_W'(($urandom_range(0, 4) == 0) ?
                      $urandom_range(101, 127) : $urandom_range(0, 100)));
          end
        endcase
        @(negedge clk);
      end
      idle_level = (ph == TICK_PHASES - 1) ? 0 : ph % 3;

      if (ph == 0) begin
        // full drive under reset gains: every steering pair at both ends
        tick_q.push_back(mk_tick(1, 1, 46080, 0, 0, 0, 0, 0));
        tick_q.push_back(mk_tick(1, 1, 46080, 0, 0, 0, 0, 1));
        tick_q.push_back(mk_tick(1, 1, 46080, 0, 0, 0, 1, 0));
        tick_q.push_back(mk_tick(1, 1, 46080, 0, 0, 0, 1, 1));
        tick_q.push_back(mk_tick(1, 1, -46080, 0, 0, 1, 0, 0));
        tick_q.push_back(mk_tick(1, 1, -46080, 0, 1, 0, 0, 0));
        tick_q.push_back(mk_tick(1, 1, -46080, 0, 1, 1, 1, 1));
        tick_q.push_back(mk_tick(1, 1, -46080, 0, 0, 0, 1, 0));
        // stale sample holds the last command
        tick_q.push_back(mk_tick(1, 0, 0, 0, 1, 1, 1, 1));
        // pitch and rate patterns at the ends of their fields
        tick_q.push_back(mk_tick(1, 1, 65535, 0, 0, 0, 0, 0));
        tick_q.push_back(mk_tick(1, 1, -65536, 0, 0, 0, 0, 0));
        tick_q.push_back(mk_tick(1, 1, 0, 32767, 1, 1, 1, 1));
        tick_q.push_back(mk_tick(1, 1, 0, -32768, 0, 0, 0, 0));
        // zero output and partial duty around the counter
        tick_q.push_back(mk_tick(1, 1, 1000, 0, 0, 0, 0, 1));
        tick_q.push_back(mk_tick(1, 1, 200, 0, 0, 0, 0, 1));
        tick_q.push_back(mk_tick(1, 1, -1000, 0, 1, 0, 0, 0));
        tick_q.push_back(mk_tick(1, 1, -1, 0, 0, 0, 0, 0));
        // run off clears, then restart
        tick_q.push_back(mk_tick(0, 1, 46080, 0, 0, 0, 0, 0));
        tick_q.push_back(mk_tick(0, 0, -46080, 0, 1, 1, 1, 1));
        tick_q.push_back(mk_tick(1, 0, 0, 0, 0, 0, 0, 0));
        tick_q.push_back(mk_tick(1, 1, 2000, 0, 0, 0, 1, 0));
      end

      for (int n = 0; n < TICKS_PER_PHASE; n++) begin
        t.run          = ($urandom_range(0, 39) != 0);
        t.sample_valid = ($urandom_range(0, 7) != 0);
        case ($urandom_range(0, 9))
          0:       t.pitch_angle = ANGLE_W'($urandom);
          1, 2, 3: t.pitch_angle = ANGLE_W'(int'($urandom_range(0, 92160)) - 46080);
          default: t.pitch_angle = ANGLE_W'(int'($urandom_range(0, 3000)) - 1500);
        endcase
        if ($urandom_range(0, 3) == 0) t.angular_rate = RATE_W'($urandom);
        else t.angular_rate = RATE_W'(int'($urandom_range(0, 400)) - 200);
        t.front_left_line  = 1'($urandom_range(0, 1));
        t.front_right_line = 1'($urandom_range(0, 1));
        t.rear_left_line   = 1'($urandom_range(0, 1));
        t.rear_right_line  = 1'($urandom_range(0, 1));
        tick_q.push_back(t);
      end
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
